### rtl/frq_pkg.sv
// Shared types and constants for the ready queue with removal.
// Depends on nothing; imported by fifo_ready_queue_with_removal.
package frq_pkg;

   localparam int DEPTH    = 16;
   localparam int ID_WIDTH = 16;
   localparam int PTR_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      OP_ADMIT  = 2'd0,
      OP_REMOVE = 2'd1,
      OP_NEXT   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_POP   = 4'b0010,
      S_SCAN  = 4'b0100,
      S_SHIFT = 4'b1000
   } state_type;

   // Physical slot of queue position off, counted from the head, in the ring.
   function automatic logic [PTR_W-1:0] ring_pos(input logic [PTR_W-1:0] head,
                                                 input logic [CNT_W:0]   off);
      logic [CNT_W+1:0] sum;
      sum = {{(CNT_W+2-PTR_W){1'b0}}, head} + {1'b0, off};
      if (sum >= (CNT_W+2)'(DEPTH)) begin
         sum = sum - (CNT_W+2)'(DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

endpackage

### rtl/fifo_ready_queue_with_removal.sv
// Ready queue of thread identifiers with admit, remove and next requests.
// Ring store of DEPTH words walked by one compare/copy sequencer; uses frq_pkg.
// Admit, empty/full cases and unused op answer in the cycle after accept; next
// answers from S_POP; remove scans entries in S_SCAN up to the match, then moves
// each later entry down one slot in S_SHIFT, one word at a time through the
// single read port of the ring store. busy stays high until the result.
// Reset (synchronous) empties the queue at once; no clearing pass is needed.
module fifo_ready_queue_with_removal
   import frq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_op,
   input  logic [ID_WIDTH-1:0] req_thread_id,
   output logic                rsp_valid,
   output logic [ID_WIDTH-1:0] rsp_thread_out,
   output logic [1:0]          rsp_status,
   output logic [CNT_W-1:0]    rsp_queue_length
);

   logic [ID_WIDTH-1:0] mem [DEPTH];

   state_type           state_ff, state_in;
   logic [PTR_W-1:0]    head_ff, head_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    off_ff, off_in;
   logic [ID_WIDTH-1:0] id_ff, id_in;
   logic [ID_WIDTH-1:0] rd_data_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [ID_WIDTH-1:0] rsp_thread_ff, rsp_thread_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]    rsp_len_ff, rsp_len_in;

   logic                wr_en;
   logic [PTR_W-1:0]    wr_addr;
   logic [ID_WIDTH-1:0] wr_data;
   logic [PTR_W-1:0]    rd_addr;

   logic [CNT_W:0]      cnt_ext;
   logic [CNT_W:0]      off_p1;
   logic [CNT_W:0]      off_p2;

   assign cnt_ext = {1'b0, count_ff};
   assign off_p1  = {1'b0, off_ff} + (CNT_W+1)'(1);
   assign off_p2  = {1'b0, off_ff} + (CNT_W+1)'(2);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      off_in        = off_ff;
      id_in         = id_ff;
      rsp_valid_in  = 1'b0;
      rsp_thread_in = '0;
      rsp_status_in = ST_OK;
      wr_en         = 1'b0;
      wr_addr       = ring_pos(head_ff, cnt_ext);
      wr_data       = req_thread_id;
      rd_addr       = head_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (op_type'(req_op))
                  OP_ADMIT: begin
                     rsp_valid_in = 1'b1;
                     if (cnt_ext == (CNT_W+1)'(DEPTH)) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  OP_REMOVE: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_NOT_FOUND;
                     end else begin
                        id_in    = req_thread_id;
                        off_in   = '0;
                        state_in = S_SCAN;
                     end
                  end
                  OP_NEXT: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        state_in = S_POP;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_POP: begin
            rsp_valid_in  = 1'b1;
            rsp_thread_in = rd_data_ff;
            head_in       = ring_pos(head_ff, (CNT_W+1)'(1));
            count_in      = count_ff - CNT_W'(1);
            state_in      = S_IDLE;
         end
         S_SCAN: begin
            // compare the word fetched last cycle, fetch the following one
            rd_addr = ring_pos(head_ff, off_p1);
            if (rd_data_ff == id_ff) begin
               if (off_p1 == cnt_ext) begin
                  rsp_valid_in = 1'b1;
                  count_in     = count_ff - CNT_W'(1);
                  state_in     = S_IDLE;
               end else begin
                  state_in = S_SHIFT;
               end
            end else if (off_p1 == cnt_ext) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_NOT_FOUND;
               state_in      = S_IDLE;
            end else begin
               off_in = off_p1[CNT_W-1:0];
            end
         end
         S_SHIFT: begin
            // move the later word down one slot over the removed one
            wr_en   = 1'b1;
            wr_addr = ring_pos(head_ff, {1'b0, off_ff});
            wr_data = rd_data_ff;
            rd_addr = ring_pos(head_ff, off_p2);
            if (off_p2 == cnt_ext) begin
               rsp_valid_in = 1'b1;
               count_in     = count_ff - CNT_W'(1);
               state_in     = S_IDLE;
            end else begin
               off_in = off_p1[CNT_W-1:0];
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_len_in = count_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      off_ff        <= off_in;
      id_ff         <= id_in;
      rsp_thread_ff <= rsp_thread_in;
      rsp_status_ff <= rsp_status_in;
      rsp_len_ff    <= rsp_len_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_thread_out   = rsp_thread_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_queue_length = rsp_len_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, count_ff} <= (CNT_W+1)'(DEPTH))
      else $error("queue count above depth");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_IDLE))
      else $error("result shown while sequencer still busy");

   a_admit_grows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_op == OP_ADMIT && {1'b0, count_ff} < (CNT_W+1)'(DEPTH))
      |=> (count_ff == $past(count_ff) + CNT_W'(1)) && rsp_valid_ff)
      else $error("admit did not append a word");

   a_empty_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_EMPTY) |-> (rsp_len_ff == '0))
      else $error("empty status with nonzero length");

   a_len_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_len_ff == count_ff))
      else $error("reported length differs from queue count");

endmodule
